FILE: design/pfrf_pkg.sv
package pfrf_pkg;

  // Width of the microcode step counter.
  localparam int unsigned STEP_W = 3;

  // Step addresses of the microcode program.
  localparam logic [STEP_W-1:0] S_CLEAR  = 3'd0;
  localparam logic [STEP_W-1:0] S_IDLE   = 3'd1;
  localparam logic [STEP_W-1:0] S_FETCH  = 3'd2;
  localparam logic [STEP_W-1:0] S_RMW    = 3'd3;
  localparam logic [STEP_W-1:0] S_NEXTPG = 3'd4;
  localparam logic [STEP_W-1:0] S_FINISH = 3'd5;
  localparam logic [STEP_W-1:0] S_RDOUT  = 3'd6;

  // Command codes.
  localparam logic CMD_FILL = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Jump conditions of a control word.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_CLEAR,
    JC_ROW,
    JC_PAGE,
    JC_DISPATCH
  } jc_e;

  // One control word of the program.
  typedef struct packed {
    logic              busy;
    logic              clear;
    logic              load;
    logic              fetch;
    logic              wr;
    logic              pg_next;
    logic              out;
    jc_e               jc;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Microcode store: one control word per step.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      S_CLEAR: begin
        w.busy   = 1'b1;
        w.clear  = 1'b1;
        w.jc     = JC_CLEAR;
        w.target = S_CLEAR;
      end
      S_IDLE: begin
        w.load   = 1'b1;
        w.jc     = JC_DISPATCH;
        w.target = S_IDLE;
      end
      S_FETCH: begin
        w.busy   = 1'b1;
        w.fetch  = 1'b1;
        w.jc     = JC_NEXT;
        w.target = S_FETCH;
      end
      S_RMW: begin
        w.busy   = 1'b1;
        w.fetch  = 1'b1;
        w.wr     = 1'b1;
        w.jc     = JC_ROW;
        w.target = S_RMW;
      end
      S_NEXTPG: begin
        w.busy    = 1'b1;
        w.pg_next = 1'b1;
        w.jc      = JC_PAGE;
        w.target  = S_FETCH;
      end
      S_FINISH: begin
        w.busy   = 1'b1;
        w.jc     = JC_ALWAYS;
        w.target = S_IDLE;
      end
      S_RDOUT: begin
        w.busy   = 1'b1;
        w.out    = 1'b1;
        w.jc     = JC_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.busy   = 1'b1;
        w.jc     = JC_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/page_framebuffer_rect_fill.sv
// Channel   Handshake               Payload
// command   start / busy            cmd_i, x_first_i, y_first_i, x_second_i,
//                                   y_second_i, colour_i, page_i, column_i
// result    result_valid_o          pixel_byte_o
//
// A transfer on the command channel happens when start is high and busy is low.
// After reset busy stays high while a clearing pass writes every byte of the store to blank.
// A read keeps busy high for one cycle; its result is shown in that cycle and cannot stall.
// A fill keeps busy high while the read-modify-write loop runs over each page and column touched;
// a fill wholly outside the store never raises busy at all.
module page_framebuffer_rect_fill
  import pfrf_pkg::*;
#(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned PAGES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cmd_i,
  input  logic [6:0] x_first_i,
  input  logic [4:0] y_first_i,
  input  logic [6:0] x_second_i,
  input  logic [4:0] y_second_i,
  input  logic       colour_i,
  input  logic [1:0] page_i,
  input  logic [6:0] column_i,
  output logic       result_valid_o,
  output logic [7:0] pixel_byte_o
);

  localparam int unsigned CW    = $clog2(WIDTH);
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned DEPTH = PAGES * (2 ** CW);
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [8:0]    WidthV  = 9'(WIDTH);
  localparam logic [4:0]    PagesV  = 5'(PAGES);
  localparam logic [AW-1:0] LastAdr = AW'(DEPTH - 1);

  // Sequencer and datapath registers.
  logic [STEP_W-1:0] upc_q, upc_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [CW-1:0]     col_q, col_d;
  logic [CW-1:0]     wcol_q, wcol_d;
  logic [CW-1:0]     x_lo_q, x_lo_d;
  logic [CW-1:0]     x_hi_q, x_hi_d;
  logic [4:0]        y_lo_q, y_lo_d;
  logic [4:0]        y_hi_q, y_hi_d;
  logic [1:0]        pg_q, pg_d;
  logic [1:0]        pg_hi_q, pg_hi_d;
  logic              colour_q, colour_d;
  logic              rd_ok_q, rd_ok_d;

  ctrl_t ctrl;
  logic  accept;

  // Command decode signals.
  logic [6:0] xa, xb;
  logic [4:0] ya, yb;
  logic       fill_live;

  // Memory port signals.
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // Row mask of the current page.
  logic [2:0] bit_lo, bit_hi;
  logic [7:0] row_mask;

  // Current control word.
  assign ctrl   = ucode(upc_q);
  assign busy   = ctrl.busy;
  assign accept = start && !busy;

  // Put each axis of the rectangle in order and check that it reaches the store.
  assign xa = (x_first_i <= x_second_i) ? x_first_i : x_second_i;
  assign xb = (x_first_i <= x_second_i) ? x_second_i : x_first_i;
  assign ya = (y_first_i <= y_second_i) ? y_first_i : y_second_i;
  assign yb = (y_first_i <= y_second_i) ? y_second_i : y_first_i;
  assign fill_live = ({2'b00, xa} < WidthV) && ({3'b000, ya[4:3]} < PagesV);

  // Next step of the program.
  always_comb begin
    upc_d = upc_q + STEP_W'(1);
    case (ctrl.jc)
      JC_NEXT:   upc_d = upc_q + STEP_W'(1);
      JC_ALWAYS: upc_d = ctrl.target;
      JC_CLEAR:  upc_d = (clr_q != LastAdr) ? ctrl.target : upc_q + STEP_W'(1);
      JC_ROW:    upc_d = (wcol_q != x_hi_q) ? ctrl.target : upc_q + STEP_W'(1);
      JC_PAGE:   upc_d = (pg_q != pg_hi_q) ? ctrl.target : upc_q + STEP_W'(1);
      JC_DISPATCH: begin
        if (!accept) begin
          upc_d = ctrl.target;
        end else if (cmd_i == CMD_READ) begin
          upc_d = S_RDOUT;
        end else if (fill_live) begin
          upc_d = upc_q + STEP_W'(1);
        end else begin
          upc_d = ctrl.target;
        end
      end
      default:   upc_d = S_IDLE;
    endcase
  end

  // Datapath register updates under the control word.
  always_comb begin
    clr_d    = clr_q;
    col_d    = col_q;
    wcol_d   = wcol_q;
    x_lo_d   = x_lo_q;
    x_hi_d   = x_hi_q;
    y_lo_d   = y_lo_q;
    y_hi_d   = y_hi_q;
    pg_d     = pg_q;
    pg_hi_d  = pg_hi_q;
    colour_d = colour_q;
    rd_ok_d  = rd_ok_q;
    if (ctrl.clear) begin
      clr_d = clr_q + AW'(1);
    end
    if (ctrl.load && accept) begin
      x_lo_d   = CW'(xa);
      x_hi_d   = ({2'b00, xb} >= WidthV) ? CW'(WIDTH - 1) : CW'(xb);
      y_lo_d   = ya;
      y_hi_d   = yb;
      pg_d     = ya[4:3];
      pg_hi_d  = ({3'b000, yb[4:3]} >= PagesV) ? 2'(PAGES - 1) : yb[4:3];
      col_d    = CW'(xa);
      colour_d = colour_i;
      rd_ok_d  = ({3'b000, page_i} < PagesV) && ({2'b00, column_i} < WidthV);
    end
    if (ctrl.fetch) begin
      wcol_d = col_q;
      col_d  = col_q + CW'(1);
    end
    if (ctrl.pg_next) begin
      pg_d  = pg_q + 2'd1;
      col_d = x_lo_q;
    end
  end

  // Control state is reset; the clearing pass runs first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_CLEAR;
      clr_q <= '0;
    end else begin
      upc_q <= upc_d;
      clr_q <= clr_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    col_q    <= col_d;
    wcol_q   <= wcol_d;
    x_lo_q   <= x_lo_d;
    x_hi_q   <= x_hi_d;
    y_lo_q   <= y_lo_d;
    y_hi_q   <= y_hi_d;
    pg_q     <= pg_d;
    pg_hi_q  <= pg_hi_d;
    colour_q <= colour_d;
    rd_ok_q  <= rd_ok_d;
  end

  // Bits of the current page that fall inside the rectangle.
  always_comb begin
    bit_lo   = (pg_q == y_lo_q[4:3]) ? y_lo_q[2:0] : 3'd0;
    bit_hi   = (pg_q == y_hi_q[4:3]) ? y_hi_q[2:0] : 3'd7;
    row_mask = (8'hFF << bit_lo) & (8'hFF >> (3'd7 - bit_hi));
  end

  // Memory ports: clearing writes, read-modify-write, and command reads.
  always_comb begin
    mem_we    = ctrl.clear || ctrl.wr;
    mem_waddr = AW'({PW'(pg_q), wcol_q});
    mem_wdata = colour_q ? (mem_rdata & ~row_mask) : (mem_rdata | row_mask);
    if (ctrl.clear) begin
      mem_waddr = clr_q;
      mem_wdata = 8'hFF;
    end
    if (ctrl.load) begin
      mem_raddr = AW'({PW'(page_i), CW'(column_i)});
    end else begin
      mem_raddr = AW'({PW'(pg_q), col_q});
    end
  end

  pfrf_ram #(
    .DATA_W(8),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Result transfer: the stored byte inverted, or blank outside the store.
  assign result_valid_o = ctrl.out;
  assign pixel_byte_o   = rd_ok_q ? ~mem_rdata : 8'h00;

`ifndef ASSERT_OFF
  // A result is only shown while the block reports busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result shown while idle");

  // A read transfer gives its result in the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_READ) |=> result_valid_o)
    else $error("read result missing");

  // A fill transfer never gives a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_FILL) |=> !result_valid_o)
    else $error("fill produced a result");

  // The frame memory is never written while the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == S_IDLE) |-> !mem_we)
    else $error("memory written while idle");
`endif

endmodule

FILE: design/pfrf_ram.sv
module pfrf_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
